>>> hw/rtl/dcps_pkg.sv
// Shared types and constants for the dual channel converter poll sequencer.
`timescale 1ns / 1ps
`default_nettype none

package dcps_pkg;

    typedef enum logic [1:0] {
        KIND_NONE,
        KIND_WRITE,
        KIND_READ,
        KIND_UPDATE
    } kind_t;

    typedef struct packed {
        logic        enabled;
        logic [6:0]  device_addr;
        logic [15:0] chan1_config;
        logic [15:0] chan2_config;
    } cfg_t;

    typedef struct packed {
        kind_t       kind;
        logic [6:0]  slave_addr;
        logic [1:0]  byte_count;
        logic [7:0]  tx_byte0;
        logic [7:0]  tx_byte1;
        logic [7:0]  tx_byte2;
        logic [1:0]  reg_offset;
        logic [15:0] reg_value;
        logic        bus_released;
        logic        last;
    } res_t;

    // register indexes on the config port
    localparam logic [7:0] REG_ENABLED      = 8'd0;
    localparam logic [7:0] REG_DEVICE_ADDR  = 8'd1;
    localparam logic [7:0] REG_CHAN1_CONFIG = 8'd2;
    localparam logic [7:0] REG_CHAN2_CONFIG = 8'd3;

    localparam logic        RST_ENABLED      = 1'b1;
    localparam logic [6:0]  RST_DEVICE_ADDR  = 7'h48;
    localparam logic [15:0] RST_CHAN1_CONFIG = 16'h8303;
    localparam logic [15:0] RST_CHAN2_CONFIG = 16'hB303;

    // sub-steps within one channel's conversion
    localparam logic [2:0] SUB_START    = 3'd0;
    localparam logic [2:0] SUB_RELEASE  = 3'd1;
    localparam logic [2:0] SUB_READ_CFG = 3'd2;
    localparam logic [2:0] SUB_CHECK    = 3'd3;
    localparam logic [2:0] SUB_POINT    = 3'd4;
    localparam logic [2:0] SUB_READ_CNV = 3'd5;
    localparam logic [2:0] SUB_STORE    = 3'd6;

    localparam logic [3:0] CHAN2_BASE = 4'd7;
    localparam logic [3:0] LAST_STEP  = 4'd13;

    localparam logic [1:0] OFF_CHAN1 = 2'd0;
    localparam logic [1:0] OFF_CHAN2 = 2'd1;
    localparam logic [1:0] OFF_COUNT = 2'd2;

    localparam logic [1:0] CNT_CFG_WRITE = 2'd3;
    localparam logic [1:0] CNT_PTR_WRITE = 2'd1;
    localparam logic [1:0] CNT_READ      = 2'd2;

    localparam logic [7:0] CFG_POINTER  = 8'h01;
    localparam logic [7:0] CONV_POINTER = 8'h00;
    localparam int         READY_BIT    = 7;

    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

endpackage

`default_nettype wire

>>> hw/rtl/dual_channel_adc_poll_sequencer.sv
// Top level: poll input register, config registers, sequencer step logic and result queue.
// A poll request accepted into the input register is stepped once the result queue
//   has room; its results are written into the queue and show on the m_ side from then on.
// Throughput: one poll per cycle while the result queue has room; a store step emits
//   two results, drained one per cycle while m_tready is high.
// Reset: sequence at channel one start, not-ready count 0, config to defaults.
`timescale 1ns / 1ps
`default_nettype none

module dual_channel_adc_poll_sequencer (
    input  wire         aclk,
    input  wire         aresetn,
    // config write channel
    input  wire         cfg_valid,
    output logic        cfg_ready,
    input  wire [7:0]   cfg_index,
    input  wire [15:0]  cfg_data,
    // poll requests
    input  wire         s_tvalid,
    output logic        s_tready,
    input  wire [15:0]  s_tdata,   // rx_high[7:0], rx_low[15:8]
    input  wire [0:0]   s_tuser,   // transfer_done[0]
    // results
    output logic        m_tvalid,
    input  wire         m_tready,
    output logic [55:0] m_tdata,   // slave_addr[6:0], byte_count[8:7], tx_byte0[16:9],
                                   // tx_byte1[24:17], tx_byte2[32:25], reg_offset[34:33],
                                   // reg_value[50:35], bus_released[51], zero[55:52]
    output logic [1:0]  m_tuser,   // kind[1:0]
    output logic        m_tlast
);
    import dcps_pkg::*;

    cfg_t       cfg;
    res_t       res0;
    res_t       res1;
    res_t       head;
    logic [1:0] res_count;
    logic       room;
    logic       consume;

    logic       in_valid_reg;
    logic       in_done_reg;
    logic [7:0] in_high_reg;
    logic [7:0] in_low_reg;

    assign cfg_ready = 1'b1;
    assign consume   = in_valid_reg && room;
    assign s_tready  = !in_valid_reg || room;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_done_reg <= s_tuser[0];
            in_high_reg <= s_tdata[7:0];
            in_low_reg  <= s_tdata[15:8];
        end
    end

    dcps_cfg_regs u_cfg (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_en    (cfg_valid && cfg_ready),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .cfg      (cfg)
    );

    dcps_step u_step (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .fire          (consume),
        .transfer_done (in_done_reg),
        .rx_high       (in_high_reg),
        .rx_low        (in_low_reg),
        .cfg           (cfg),
        .res0          (res0),
        .res1          (res1),
        .res_count     (res_count)
    );

    dcps_out_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_count (res_count),
        .push0      (res0),
        .push1      (res1),
        .room       (room),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_res    (head)
    );

    assign m_tdata = {4'b0000, head.bus_released, head.reg_value, head.reg_offset,
                      head.tx_byte2, head.tx_byte1, head.tx_byte0,
                      head.byte_count, head.slave_addr};
    assign m_tuser = head.kind;
    assign m_tlast = head.last;

endmodule

`default_nettype wire

>>> hw/rtl/dcps_cfg_regs.sv
// Configuration register bank for the poll sequencer.
`timescale 1ns / 1ps
`default_nettype none

module dcps_cfg_regs (
    input  wire               aclk,
    input  wire               aresetn,
    input  wire               wr_en,
    input  wire [7:0]         wr_index,
    input  wire [15:0]        wr_data,
    output dcps_pkg::cfg_t    cfg
);
    import dcps_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb begin
        cfg_next = cfg_reg;
        if (wr_en) begin
            case (wr_index)
                REG_ENABLED:      cfg_next.enabled      = wr_data[0];
                REG_DEVICE_ADDR:  cfg_next.device_addr  = wr_data[6:0];
                REG_CHAN1_CONFIG: cfg_next.chan1_config = wr_data;
                REG_CHAN2_CONFIG: cfg_next.chan2_config = wr_data;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.enabled      <= RST_ENABLED;
            cfg_reg.device_addr  <= RST_DEVICE_ADDR;
            cfg_reg.chan1_config <= RST_CHAN1_CONFIG;
            cfg_reg.chan2_config <= RST_CHAN2_CONFIG;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

>>> hw/rtl/dcps_step.sv
// Sequence state and per-poll result generation.
`timescale 1ns / 1ps
`default_nettype none

module dcps_step (
    input  wire                  aclk,
    input  wire                  aresetn,
    input  wire                  fire,
    input  wire                  transfer_done,
    input  wire [7:0]            rx_high,
    input  wire [7:0]            rx_low,
    input  wire dcps_pkg::cfg_t  cfg,
    output dcps_pkg::res_t       res0,
    output dcps_pkg::res_t       res1,
    output logic [1:0]           res_count
);
    import dcps_pkg::*;

    logic [3:0]  step_reg;
    logic [3:0]  step_next;
    logic [15:0] count_reg;
    logic [15:0] count_next;

    logic [3:0]  step_n;
    logic        ch;
    logic [2:0]  sub;
    logic [3:0]  base;
    logic [15:0] cfg_word;

    always_comb begin
        step_n   = (step_reg > LAST_STEP) ? 4'd0 : step_reg;
        ch       = (step_n >= CHAN2_BASE);
        sub      = ch ? 3'(step_n - CHAN2_BASE) : step_n[2:0];
        base     = ch ? CHAN2_BASE : 4'd0;
        cfg_word = ch ? cfg.chan2_config : cfg.chan1_config;

        res0       = '0;
        res1       = '0;
        res_count  = 2'd0;
        step_next  = step_reg;
        count_next = count_reg;

        if (fire && transfer_done && cfg.enabled) begin
            res_count = 2'd1;
            res0.last = 1'b1;
            case (sub)
                SUB_START: begin
                    count_next      = 16'd0;
                    res0.kind       = KIND_WRITE;
                    res0.slave_addr = cfg.device_addr;
                    res0.byte_count = CNT_CFG_WRITE;
                    res0.tx_byte0   = CFG_POINTER;
                    res0.tx_byte1   = cfg_word[15:8];
                    res0.tx_byte2   = cfg_word[7:0];
                    step_next       = base + {1'b0, SUB_RELEASE};
                end
                SUB_RELEASE: begin
                    res0.bus_released = 1'b1;
                    step_next         = base + {1'b0, SUB_READ_CFG};
                end
                SUB_READ_CFG, SUB_READ_CNV: begin
                    res0.kind       = KIND_READ;
                    res0.slave_addr = cfg.device_addr;
                    res0.byte_count = CNT_READ;
                    step_next       = base + {1'b0, 3'(sub + 3'd1)};
                end
                SUB_CHECK: begin
                    res0.bus_released = 1'b1;
                    if (rx_high[READY_BIT]) begin
                        step_next = base + {1'b0, SUB_POINT};
                    end else begin
                        count_next = count_reg + 16'd1;
                        step_next  = base + {1'b0, SUB_READ_CFG};
                    end
                end
                SUB_POINT: begin
                    res0.kind       = KIND_WRITE;
                    res0.slave_addr = cfg.device_addr;
                    res0.byte_count = CNT_PTR_WRITE;
                    res0.tx_byte0   = CONV_POINTER;
                    step_next       = base + {1'b0, SUB_READ_CNV};
                end
                default: begin
                    // store: channel value, then not-ready count
                    res_count         = 2'd2;
                    res0.kind         = KIND_UPDATE;
                    res0.reg_offset   = ch ? OFF_CHAN2 : OFF_CHAN1;
                    res0.reg_value    = {rx_high, rx_low};
                    res0.bus_released = 1'b1;
                    res0.last         = 1'b0;
                    res1.kind         = KIND_UPDATE;
                    res1.reg_offset   = OFF_COUNT;
                    res1.reg_value    = count_reg;
                    res1.bus_released = 1'b1;
                    res1.last         = 1'b1;
                    step_next         = ch ? 4'd0 : CHAN2_BASE;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_reg  <= 4'd0;
            count_reg <= 16'd0;
        end else begin
            step_reg  <= step_next;
            count_reg <= count_next;
        end
    end

endmodule

`default_nettype wire

>>> hw/rtl/dcps_out_queue.sv
// Small result queue taking up to two results per cycle, draining one while out_ready is high.
`timescale 1ns / 1ps
`default_nettype none

module dcps_out_queue (
    input  wire                  aclk,
    input  wire                  aresetn,
    input  wire [1:0]            push_count,
    input  wire dcps_pkg::res_t  push0,
    input  wire dcps_pkg::res_t  push1,
    output logic                 room,
    output logic                 out_valid,
    input  wire                  out_ready,
    output dcps_pkg::res_t       out_res
);
    import dcps_pkg::*;

    res_t              mem [QDEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] wr_ptr_next;
    logic [QPTR_W-1:0] wr_ptr_inc;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_next;
    logic [QCNT_W-1:0] count_reg;
    logic [QCNT_W-1:0] count_next;
    logic              pop;

    always_comb begin
        pop         = out_valid && out_ready;
        wr_ptr_inc  = wr_ptr_reg + QPTR_W'(1);
        wr_ptr_next = wr_ptr_reg + QPTR_W'(push_count);
        rd_ptr_next = rd_ptr_reg + QPTR_W'(pop);
        count_next  = count_reg + QCNT_W'(push_count) - QCNT_W'(pop);
    end

    assign room      = (count_reg <= QCNT_W'(QDEPTH - 2));
    assign out_valid = (count_reg != '0);
    assign out_res   = mem[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (push_count != 2'd0) begin
            mem[wr_ptr_reg] <= push0;
        end
        if (push_count == 2'd2) begin
            mem[wr_ptr_inc] <= push1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

`default_nettype wire
